[src/quicksort_engine_defines.svh]
// ----------------------------------------------------------------------------
// quicksort engine assertion macros
// concurrent assertion wrappers used by the quicksort engine top level
// ----------------------------------------------------------------------------
`ifndef QUICKSORT_ENGINE_DEFINES_SVH
`define QUICKSORT_ENGINE_DEFINES_SVH

`ifndef ASSERT_OFF
`define QSE_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define QSE_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define QSE_ASSERT(lbl, clk, rst, prop, msg)
`define QSE_NEVER(lbl, clk, rst, cond, msg)
`endif

`endif

[src/qse_pkg.sv]
// ----------------------------------------------------------------------------
// quicksort engine package
// sizes, sequencer states and port structs shared by the engine modules
// ----------------------------------------------------------------------------
package qse_pkg;

   localparam int MAX_ITEMS = 64;
   localparam int VALUE_W   = 32;
   localparam int ADDR_W    = $clog2(MAX_ITEMS);
   localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
   localparam int STACK_W   = 2 * ADDR_W;

   localparam logic [CNT_W-1:0]  MAX_COUNT = CNT_W'(MAX_ITEMS);
   localparam logic [CNT_W-1:0]  CNT_ONE   = CNT_W'(1);
   localparam logic [CNT_W-1:0]  CNT_TWO   = CNT_W'(2);
   localparam logic [ADDR_W-1:0] ADDR_ONE  = ADDR_W'(1);
   localparam logic [ADDR_W:0]   WIDE_ONE  = (ADDR_W + 1)'(1);

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_START,
      ST_POP,
      ST_POPD,
      ST_PIV,
      ST_LOOP,
      ST_RDV,
      ST_RDL,
      ST_WRL,
      ST_PUSHL,
      ST_PUSHR,
      ST_EMIT_RD,
      ST_EMIT_LD
   } qse_state_type;

   typedef struct packed {
      logic                wr_en;
      logic [ADDR_W-1:0]   wr_addr;
      logic [VALUE_W-1:0]  wr_data;
      logic                rd_en;
      logic [ADDR_W-1:0]   rd_addr;
   } qse_store_port_type;

   typedef struct packed {
      logic                wr_en;
      logic [ADDR_W-1:0]   wr_addr;
      logic [STACK_W-1:0]  wr_data;
      logic                rd_en;
      logic [ADDR_W-1:0]   rd_addr;
   } qse_stack_port_type;

   typedef struct packed {
      logic [VALUE_W-1:0]  value;
      logic                last;
      logic                overflow;
   } qse_result_type;

   typedef struct packed {
      qse_state_type       state;
      logic [CNT_W-1:0]    count;
      logic [CNT_W-1:0]    sp;
   } qse_status_type;

endpackage

[src/qse_ram.sv]
// ----------------------------------------------------------------------------
// qse_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module qse_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/qse_ctrl.sv]
// ----------------------------------------------------------------------------
// qse_ctrl
// load, partition and emit sequencer working on the element and range rams
// ----------------------------------------------------------------------------
module qse_ctrl (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [qse_pkg::VALUE_W-1:0]      req_value,
   input  logic                             req_last,
   output qse_pkg::qse_store_port_type      store_port,
   input  logic [qse_pkg::VALUE_W-1:0]      store_rdata,
   output qse_pkg::qse_stack_port_type      stack_port,
   input  logic [qse_pkg::STACK_W-1:0]      stack_rdata,
   input  logic                             out_free,
   output logic                             res_emit,
   output qse_pkg::qse_result_type          result,
   output qse_pkg::qse_status_type          status
);

   qse_pkg::qse_state_type              state_ff, state_in;
   logic [qse_pkg::CNT_W-1:0]           count_ff, count_in;
   logic [qse_pkg::CNT_W-1:0]           sp_ff, sp_in;
   logic [qse_pkg::CNT_W-1:0]           k_ff, k_in;
   logic                                dropped_ff, dropped_in;
   logic [qse_pkg::ADDR_W-1:0]          lo_ff, lo_in;
   logic [qse_pkg::ADDR_W-1:0]          hi_ff, hi_in;
   logic [qse_pkg::ADDR_W-1:0]          first_ff, first_in;
   logic [qse_pkg::ADDR_W-1:0]          last_ff, last_in;
   logic [qse_pkg::VALUE_W-1:0]         pivot_ff, pivot_in;
   logic [qse_pkg::VALUE_W-1:0]         v_ff, v_in;

   logic [qse_pkg::CNT_W-1:0]           count_dec;
   logic [qse_pkg::CNT_W-1:0]           sp_dec;
   logic [qse_pkg::CNT_W-1:0]           k_inc;
   logic [qse_pkg::ADDR_W-1:0]          pop_first;
   logic [qse_pkg::ADDR_W-1:0]          pop_last;
   logic [qse_pkg::ADDR_W:0]            hi_wide;
   logic [qse_pkg::ADDR_W:0]            hi_wide_inc;
   logic [qse_pkg::ADDR_W:0]            first_wide_inc;

   assign count_dec      = count_ff - qse_pkg::CNT_ONE;
   assign sp_dec         = sp_ff - qse_pkg::CNT_ONE;
   assign k_inc          = k_ff + qse_pkg::CNT_ONE;
   assign pop_first      = stack_rdata[qse_pkg::STACK_W-1:qse_pkg::ADDR_W];
   assign pop_last       = stack_rdata[qse_pkg::ADDR_W-1:0];
   assign hi_wide        = {1'b0, hi_ff};
   assign hi_wide_inc    = hi_wide + qse_pkg::WIDE_ONE;
   assign first_wide_inc = {1'b0, first_ff} + qse_pkg::WIDE_ONE;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= qse_pkg::ST_LOAD;
         count_ff   <= '0;
         sp_ff      <= '0;
         k_ff       <= '0;
         dropped_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         sp_ff      <= sp_in;
         k_ff       <= k_in;
         dropped_ff <= dropped_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      first_ff <= first_in;
      last_ff  <= last_in;
      pivot_ff <= pivot_in;
      v_ff     <= v_in;
   end

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      sp_in      = sp_ff;
      k_in       = k_ff;
      dropped_in = dropped_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      first_in   = first_ff;
      last_in    = last_ff;
      pivot_in   = pivot_ff;
      v_in       = v_ff;
      req_ready  = 1'b0;
      res_emit   = 1'b0;
      store_port = '0;
      stack_port = '0;
      result.value    = store_rdata;
      result.last     = (k_inc == count_ff);
      result.overflow = dropped_ff;

      unique case (state_ff)
         qse_pkg::ST_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (count_ff < qse_pkg::MAX_COUNT) begin
                  store_port.wr_en   = 1'b1;
                  store_port.wr_addr = count_ff[qse_pkg::ADDR_W-1:0];
                  store_port.wr_data = req_value;
                  count_in           = count_ff + qse_pkg::CNT_ONE;
               end else begin
                  dropped_in = 1'b1;
               end
               if (req_last) begin
                  state_in = qse_pkg::ST_START;
               end
            end
         end
         qse_pkg::ST_START: begin
            if (count_ff >= qse_pkg::CNT_TWO) begin
               stack_port.wr_en   = 1'b1;
               stack_port.wr_addr = '0;
               stack_port.wr_data = {{qse_pkg::ADDR_W{1'b0}},
                                     count_dec[qse_pkg::ADDR_W-1:0]};
               sp_in = qse_pkg::CNT_ONE;
            end else begin
               sp_in = '0;
            end
            state_in = qse_pkg::ST_POP;
         end
         qse_pkg::ST_POP: begin
            if (sp_ff == '0) begin
               k_in     = '0;
               state_in = qse_pkg::ST_EMIT_RD;
            end else begin
               stack_port.rd_en   = 1'b1;
               stack_port.rd_addr = sp_dec[qse_pkg::ADDR_W-1:0];
               sp_in              = sp_dec;
               state_in           = qse_pkg::ST_POPD;
            end
         end
         qse_pkg::ST_POPD: begin
            first_in = pop_first;
            last_in  = pop_last;
            if (pop_first >= pop_last) begin
               state_in = qse_pkg::ST_POP;
            end else begin
               lo_in              = pop_first;
               hi_in              = pop_last;
               store_port.rd_en   = 1'b1;
               store_port.rd_addr = pop_last;
               state_in           = qse_pkg::ST_PIV;
            end
         end
         qse_pkg::ST_PIV: begin
            pivot_in = store_rdata;
            state_in = qse_pkg::ST_LOOP;
         end
         qse_pkg::ST_LOOP: begin
            if (lo_ff < hi_ff) begin
               store_port.rd_en   = 1'b1;
               store_port.rd_addr = hi_ff - qse_pkg::ADDR_ONE;
               state_in           = qse_pkg::ST_RDV;
            end else begin
               // pivot drops into its final slot
               store_port.wr_en   = 1'b1;
               store_port.wr_addr = hi_ff;
               store_port.wr_data = pivot_ff;
               state_in           = qse_pkg::ST_PUSHL;
            end
         end
         qse_pkg::ST_RDV: begin
            if ($signed(store_rdata) > $signed(pivot_ff)) begin
               store_port.wr_en   = 1'b1;
               store_port.wr_addr = hi_ff;
               store_port.wr_data = store_rdata;
               hi_in              = hi_ff - qse_pkg::ADDR_ONE;
               state_in           = qse_pkg::ST_LOOP;
            end else begin
               v_in               = store_rdata;
               store_port.rd_en   = 1'b1;
               store_port.rd_addr = lo_ff;
               state_in           = qse_pkg::ST_RDL;
            end
         end
         qse_pkg::ST_RDL: begin
            store_port.wr_en   = 1'b1;
            store_port.wr_addr = hi_ff - qse_pkg::ADDR_ONE;
            store_port.wr_data = store_rdata;
            state_in           = qse_pkg::ST_WRL;
         end
         qse_pkg::ST_WRL: begin
            store_port.wr_en   = 1'b1;
            store_port.wr_addr = lo_ff;
            store_port.wr_data = v_ff;
            lo_in              = lo_ff + qse_pkg::ADDR_ONE;
            state_in           = qse_pkg::ST_LOOP;
         end
         qse_pkg::ST_PUSHL: begin
            if ((hi_wide > first_wide_inc) && (sp_ff < qse_pkg::MAX_COUNT)) begin
               stack_port.wr_en   = 1'b1;
               stack_port.wr_addr = sp_ff[qse_pkg::ADDR_W-1:0];
               stack_port.wr_data = {first_ff, hi_ff - qse_pkg::ADDR_ONE};
               sp_in              = sp_ff + qse_pkg::CNT_ONE;
            end
            state_in = qse_pkg::ST_PUSHR;
         end
         qse_pkg::ST_PUSHR: begin
            if ((hi_wide_inc < {1'b0, last_ff}) && (sp_ff < qse_pkg::MAX_COUNT)) begin
               stack_port.wr_en   = 1'b1;
               stack_port.wr_addr = sp_ff[qse_pkg::ADDR_W-1:0];
               stack_port.wr_data = {hi_wide_inc[qse_pkg::ADDR_W-1:0], last_ff};
               sp_in              = sp_ff + qse_pkg::CNT_ONE;
            end
            state_in = qse_pkg::ST_POP;
         end
         qse_pkg::ST_EMIT_RD: begin
            store_port.rd_en   = 1'b1;
            store_port.rd_addr = k_ff[qse_pkg::ADDR_W-1:0];
            state_in           = qse_pkg::ST_EMIT_LD;
         end
         qse_pkg::ST_EMIT_LD: begin
            if (out_free) begin
               res_emit = 1'b1;
               if (k_inc == count_ff) begin
                  count_in   = '0;
                  dropped_in = 1'b0;
                  sp_in      = '0;
                  state_in   = qse_pkg::ST_LOAD;
               end else begin
                  k_in     = k_inc;
                  state_in = qse_pkg::ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = qse_pkg::ST_LOAD;
         end
      endcase
   end

   assign status.state = state_ff;
   assign status.count = count_ff;
   assign status.sp    = sp_ff;

endmodule

[src/quicksort_engine.sv]
// ----------------------------------------------------------------------------
// quicksort engine
// loading: one value per cycle; sorting: value moves, swaps and subranges are
// paced by the single element ram port pair; emitting: a ram read per result
// then the output register, stalled while that register is not free
// reset clears control state only, the element and range rams are not cleared
// ----------------------------------------------------------------------------
`include "quicksort_engine_defines.svh"

module quicksort_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // value
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // sorted_value
   output logic        rsp_tlast,
   output logic [0:0]  rsp_tuser    // overflow
);

   qse_pkg::qse_store_port_type         store_port;
   qse_pkg::qse_stack_port_type         stack_port;
   qse_pkg::qse_result_type             result;
   qse_pkg::qse_status_type             status;
   logic [qse_pkg::VALUE_W-1:0]         store_rdata;
   logic [qse_pkg::STACK_W-1:0]         stack_rdata;
   logic                                res_emit;
   logic                                out_free;

   logic                                rsp_valid_ff, rsp_valid_in;
   logic [qse_pkg::VALUE_W-1:0]         rsp_data_ff, rsp_data_in;
   logic                                rsp_last_ff, rsp_last_in;
   logic                                rsp_ovf_ff, rsp_ovf_in;

   qse_ram #(
      .WIDTH (qse_pkg::VALUE_W),
      .DEPTH (qse_pkg::MAX_ITEMS)
   ) u_store_ram (
      .clock   (clock),
      .wr_en   (store_port.wr_en),
      .wr_addr (store_port.wr_addr),
      .wr_data (store_port.wr_data),
      .rd_en   (store_port.rd_en),
      .rd_addr (store_port.rd_addr),
      .rd_data (store_rdata)
   );

   qse_ram #(
      .WIDTH (qse_pkg::STACK_W),
      .DEPTH (qse_pkg::MAX_ITEMS)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (stack_port.wr_en),
      .wr_addr (stack_port.wr_addr),
      .wr_data (stack_port.wr_data),
      .rd_en   (stack_port.rd_en),
      .rd_addr (stack_port.rd_addr),
      .rd_data (stack_rdata)
   );

   qse_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_value   (req_tdata),
      .req_last    (req_tlast),
      .store_port  (store_port),
      .store_rdata (store_rdata),
      .stack_port  (stack_port),
      .stack_rdata (stack_rdata),
      .out_free    (out_free),
      .res_emit    (res_emit),
      .result      (result),
      .status      (status)
   );

   // output register, free when empty or being taken this cycle
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      if (res_emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result.value;
         rsp_last_in  = result.last;
         rsp_ovf_in   = result.overflow;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_ovf_ff;

   `QSE_ASSERT(count_bound_a, clock, reset, status.count <= qse_pkg::MAX_COUNT, "count overrun")
   `QSE_ASSERT(stack_bound_a, clock, reset, status.sp <= qse_pkg::MAX_COUNT, "stack overrun")
   `QSE_ASSERT(emit_free_a, clock, reset, res_emit |-> out_free, "output register busy")
   `QSE_NEVER(load_stack_a, clock, reset, req_tready && (status.sp != '0), "ranges left stacked")

endmodule

[verif/tb_quicksort_engine.sv]
// ----------------------------------------------------------------------------
// quicksort engine testbench
// streams runs of signed values into the engine, sorts each run in a local
// model when its last value is accepted, and compares every sorted result
// (value, end of run, overflow flag) against the oldest expected transaction.
// covers single-value runs, extreme and duplicate values, ordered inputs, a
// full store, dropped values, and random runs under several idling regimes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_quicksort_engine;

   localparam logic [31:0] MOST_POSITIVE = 32'h7fff_ffff;
   localparam logic [31:0] MOST_NEGATIVE = 32'h8000_0000;
   localparam int          DRAIN_LIMIT   = 200000;
   localparam int          SETTLE_CYCLES = 50;
   localparam longint      TIMEOUT_NS    = 4000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;     // value
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;          // sorted_value
   logic        rsp_tlast;
   logic [0:0]  rsp_tuser;          // overflow

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int mismatch_count = 0;

   // run being collected and sorted results still owed by the engine
   logic [31:0]             held_values[$];
   logic                    values_dropped = 1'b0;
   qse_pkg::qse_result_type pending_results[$];

   quicksort_engine u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   always @(negedge clock) begin
      rsp_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %h, expected %h", what, got, want);
      mismatch_count++;
   endtask

   function automatic void sort_held_values();
      int          i;
      int          j;
      logic [31:0] key;
      for (i = 1; i < held_values.size(); i++) begin
         key = held_values[i];
         j   = i - 1;
         while (j >= 0 && $signed(held_values[j]) > $signed(key)) begin
            held_values[j + 1] = held_values[j];
            j--;
         end
         held_values[j + 1] = key;
      end
   endfunction

   // store or drop one value; the last of a run releases the sorted results
   function automatic void collect_value(input logic [31:0] value, input logic is_last);
      int                      k;
      qse_pkg::qse_result_type res;
      if (held_values.size() < qse_pkg::MAX_ITEMS)
         held_values.push_back(value);
      else
         values_dropped = 1'b1;
      if (is_last) begin
         sort_held_values();
         for (k = 0; k < held_values.size(); k++) begin
            res.value    = held_values[k];
            res.last     = (k == held_values.size() - 1);
            res.overflow = values_dropped;
            pending_results.push_back(res);
         end
         held_values.delete();
         values_dropped = 1'b0;
      end
   endfunction

   function automatic logic [31:0] pick_value();
      logic [31:0] v;
      case ($urandom_range(3))
         0: v = 32'($urandom_range(16)) - 32'd8;
         1: v = $urandom_range(1) ? MOST_POSITIVE - 32'($urandom_range(3))
                                  : MOST_NEGATIVE + 32'($urandom_range(3));
         default: v = $urandom;
      endcase
      return v;
   endfunction

   // entered and left at a falling edge; valid stays high into the next call
   task automatic send_value(input logic [31:0] value, input logic is_last);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tlast  <= is_last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      collect_value(value, is_last);
      @(negedge clock);
   endtask

   always @(posedge clock) begin : check_results
      qse_pkg::qse_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected transaction", rsp_tdata, '0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata !== want.value)
               report_mismatch("sorted value", rsp_tdata, want.value);
            if (rsp_tlast !== want.last)
               report_mismatch("end of run", 32'(rsp_tlast), 32'(want.last));
            if (rsp_tuser[0] !== want.overflow)
               report_mismatch("overflow", 32'(rsp_tuser[0]), 32'(want.overflow));
         end
      end
   end

   task automatic set_idling(input int send_pct, input int recv_pct);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
   endtask

   task automatic send_run(input logic [31:0] values[]);
      int k;
      for (k = 0; k < values.size(); k++)
         send_value(values[k], k == values.size() - 1);
   endtask

   task automatic test_single_value();
      send_value(MOST_NEGATIVE, 1'b1);
   endtask

   task automatic test_extreme_values();
      send_run('{MOST_POSITIVE, MOST_NEGATIVE, 32'h0, 32'hffff_ffff, 32'h1,
                 MOST_POSITIVE, MOST_NEGATIVE, 32'h1});
   endtask

   task automatic test_ordered_runs();
      send_run('{32'hffff_fffe, 32'h0, 32'h3, 32'h40, 32'h7000_0000});
      send_run('{32'h7000_0000, 32'h40, 32'h3, 32'h0, 32'hffff_fffe});
      send_run('{32'h5a5a_5a5a, 32'h5a5a_5a5a, 32'h5a5a_5a5a, 32'h5a5a_5a5a});
   endtask

   // a run that fills the store and then has its tail dropped,
   // the last value of which still starts the sort
   task automatic test_full_store();
      int k;
      int extra;
      extra = $urandom_range(1, 3);
      for (k = 0; k < qse_pkg::MAX_ITEMS + extra; k++)
         send_value(pick_value(), k == qse_pkg::MAX_ITEMS + extra - 1);
   endtask

   task automatic test_random_runs(input int budget);
      int sent;
      int run_len;
      int k;
      sent = 0;
      while (sent < budget) begin
         run_len = ($urandom_range(9) == 0) ? $urandom_range(30, qse_pkg::MAX_ITEMS)
                                            : $urandom_range(1, 16);
         if (run_len > budget - sent)
            run_len = budget - sent;
         for (k = 0; k < run_len; k++)
            send_value(pick_value(), k == run_len - 1);
         sent += run_len;
      end
   endtask

   task automatic wait_for_results();
      int waited;
      waited = 0;
      while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_single_value();
      test_extreme_values();
      test_ordered_runs();
      set_idling(70, 70);
      test_full_store();

      set_idling(0, 0);
      test_random_runs(20);
      set_idling(70, 0);
      test_random_runs(20);
      set_idling(0, 70);
      test_random_runs(20);
      set_idling(30, 30);
      test_random_runs(20);

      req_tvalid <= 1'b0;
      wait_for_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (pending_results.size() != 0)
         report_mismatch("results never delivered", '0, 32'(pending_results.size()));

      if (mismatch_count == 0) begin
         $display("PASS quicksort_engine");
      end else begin
         $display("FAIL quicksort_engine");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("FAIL quicksort_engine");
      $finish;
   end

endmodule

[filelist.f]
+incdir+src
src/qse_pkg.sv
src/qse_ram.sv
src/qse_ctrl.sv
src/quicksort_engine.sv
verif/tb_quicksort_engine.sv
